>>> rtl/qphi_pkg.sv
// qphi_pkg: shared constants and types for the quadratic probe hash insert block.
// Depends on nothing; every other file depends on it.
`default_nettype none
package qphi_pkg;

    localparam int TABLE_DEPTH   = 128;
    localparam int KEY_CHARS_MAX = 8;
    localparam int SLOT_W        = $clog2(TABLE_DEPTH);
    localparam int SIZE_W        = 8;
    localparam int KEY_W         = 64;
    localparam int LEN_W         = 4;
    localparam int HASH_W        = 32;
    localparam int CNT_W         = 8;
    localparam int TC_W          = 16;
    localparam int TOT_W         = 32;
    localparam int RESET_SIZE    = 31;
    localparam int HASH_MUL      = 27;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    // write / clear request from the sequencer to the slot store
    typedef struct packed {
        logic              clr;
        logic              wr_en;
        logic [SLOT_W-1:0] slot;
        logic [KEY_W-1:0]  key;
    } qphi_tbl_req_t;

endpackage
`default_nettype wire

>>> rtl/qphi_in_if.sv
// qphi_in_if: command channel (valid/ready) carrying one insert or clear item.
// Depends on qphi_pkg.
`default_nettype none
interface qphi_in_if;
    logic                        valid;
    logic                        ready;
    logic                        opcode;
    logic [qphi_pkg::KEY_W-1:0]  key_chars;
    logic [qphi_pkg::LEN_W-1:0]  key_length;

    modport source (output valid, output opcode, output key_chars, output key_length,
                    input ready);
    modport sink   (input valid, input opcode, input key_chars, input key_length,
                    output ready);
endinterface
`default_nettype wire

>>> rtl/qphi_out_if.sv
// qphi_out_if: result channel (valid/ready) carrying one result item per command.
// Depends on qphi_pkg.
`default_nettype none
interface qphi_out_if;
    logic                         valid;
    logic                         ready;
    logic [qphi_pkg::SLOT_W-1:0]  slot_index;
    logic [qphi_pkg::CNT_W-1:0]   probe_collisions;
    logic [qphi_pkg::CNT_W-1:0]   entry_count;
    logic [qphi_pkg::TC_W-1:0]    table_collisions;
    logic [qphi_pkg::TOT_W-1:0]   total_collisions;
    logic                         load_half_reached;
    logic                         table_full;

    modport source (output valid, output slot_index, output probe_collisions,
                    output entry_count, output table_collisions, output total_collisions,
                    output load_half_reached, output table_full, input ready);
    modport sink   (input valid, input slot_index, input probe_collisions,
                    input entry_count, input table_collisions, input total_collisions,
                    input load_half_reached, input table_full, output ready);
endinterface
`default_nettype wire

>>> rtl/qphi_modunit.sv
// qphi_modunit: bit-serial remainder of a 32-bit magnitude by the table size.
// Depends on qphi_pkg. One dividend bit per cycle.
`default_nettype none
module qphi_modunit (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [qphi_pkg::HASH_W-1:0]  dividend,
    input  wire logic [qphi_pkg::SIZE_W-1:0]  divisor,
    output logic                              done,
    output logic [qphi_pkg::SLOT_W-1:0]       remainder
);
    import qphi_pkg::*;

    localparam int BIT_CW = $clog2(HASH_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [BIT_CW-1:0] cnt_reg, cnt_next;
    logic [HASH_W-1:0] sh_reg, sh_next;
    logic [SLOT_W-1:0] rem_reg, rem_next;
    logic [SIZE_W-1:0] trial;

    // partial remainder stays below the divisor, so the trial fits SIZE_W bits
    assign trial = {rem_reg, sh_reg[HASH_W-1]};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        sh_next   = sh_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            sh_next   = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            sh_next  = {sh_reg[HASH_W-2:0], 1'b0};
            rem_next = (trial >= divisor) ? SLOT_W'(trial - divisor) : SLOT_W'(trial);
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == BIT_CW'(HASH_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg  <= sh_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule
`default_nettype wire

>>> rtl/qphi_table.sv
// qphi_table: slot occupancy flags (flip-flops, cleared at once) and key store.
// Depends on qphi_pkg. Occupancy read is combinational at one address.
`default_nettype none
module qphi_table (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire qphi_pkg::qphi_tbl_req_t      req,
    input  wire logic [qphi_pkg::SLOT_W-1:0]  rd_slot,
    output logic                              occupied
);
    import qphi_pkg::*;

    logic [TABLE_DEPTH-1:0] occ_reg;
    logic [KEY_W-1:0]       key_mem [TABLE_DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else if (req.clr)
        begin
            occ_reg <= '0;
        end
        else if (req.wr_en)
        begin
            occ_reg[req.slot] <= 1'b1;
        end
    end

    // stored keys: no lookup path on the insert side yet
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            key_mem[req.slot] <= req.key;
        end
    end

    assign occupied = occ_reg[rd_slot];

endmodule
`default_nettype wire

>>> rtl/quadratic_probe_hash_insert_top.sv
// quadratic_probe_hash_insert_top: sequencer, hash, probe walk and result register.
// Depends on qphi_pkg, qphi_in_if, qphi_out_if, qphi_modunit, qphi_table.
//
// Usage:
//   cmd  (sink)   : one item per command; opcode insert stores key_chars/key_length,
//                   opcode clear empties occupancy, entry count and table collisions.
//   rsp  (source) : exactly one result item per command, in order.
//   cfg_we/cfg_wdata : table_size write, only while the block is idle.
// Steps of an insert: an accept step, one hash step per key character, a step
// that starts the bit-serial remainder unit, a divide state that waits through its
// serial run until done, an adjust step, then the probe walk (one occupancy test
// per probe, at most TABLE_DEPTH probes), then a finish step that loads the result
// register. A clear goes from its accept straight to the finish step.
// The serial remainder unit and the probe walk take most of the time of an insert.
// cmd.ready is high only while the sequencer is idle; a finished result sits in
// the output register, so the next item is accepted while it waits. If that
// result is still not taken when the next command finishes, the sequencer holds
// in its finish state until rsp is free.
// Reset: occupancy flags, counters and sequencer clear at once (asynchronous),
// table_size returns to 31. The key store is not cleared.
`default_nettype none
module quadratic_probe_hash_insert_top (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [qphi_pkg::SIZE_W-1:0] cfg_wdata,
    qphi_in_if.sink                          cmd,
    qphi_out_if.source                       rsp
);
    import qphi_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_HASH  = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_ADJ   = 3'd3;
    localparam logic [2:0] ST_PROBE = 3'd4;
    localparam logic [2:0] ST_FIN   = 3'd5;

    localparam logic [SIZE_W-1:0] DEPTH_SZ = SIZE_W'(TABLE_DEPTH);
    localparam logic [LEN_W-1:0]  LEN_MAX  = LEN_W'(KEY_CHARS_MAX);

    // ---------------- configuration ----------------
    logic [SIZE_W-1:0] size_reg;
    logic [SIZE_W-1:0] eff_size;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= SIZE_W'(RESET_SIZE);
        end
        else if (cfg_we)
        begin
            size_reg <= cfg_wdata;
        end
    end

    // size 0 acts as 1, anything above the store depth as the depth
    assign eff_size = (size_reg == '0)      ? SIZE_W'(1) :
                      (size_reg > DEPTH_SZ) ? DEPTH_SZ   : size_reg;

    // ---------------- sequencer registers ----------------
    logic [2:0]        state_reg, state_next;
    logic              op_reg, op_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [KEY_W-1:0]  ksh_reg, ksh_next;       // characters still to hash
    logic [LEN_W-1:0]  left_reg, left_next;     // characters still to hash
    logic [HASH_W-1:0] h_reg, h_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;     // current probe slot
    logic [SLOT_W-1:0] step_reg, step_next;     // (2i+1) mod size
    logic [SLOT_W-1:0] pi_reg, pi_next;         // probe number i
    logic [CNT_W-1:0]  hits_reg, hits_next;
    logic              found_reg, found_next;

    // counters and result register
    logic [CNT_W-1:0]  stored_reg, stored_next;
    logic [TC_W-1:0]   tc_reg, tc_next;
    logic [TOT_W-1:0]  tot_reg, tot_next;
    logic              ov_reg, ov_next;
    logic [SLOT_W-1:0] o_slot_reg, o_slot_next;
    logic [CNT_W-1:0]  o_hits_reg, o_hits_next;
    logic              o_half_reg, o_half_next;
    logic              o_full_reg, o_full_next;

    // ---------------- shared datapath pieces ----------------
    logic [LEN_W-1:0]  len_c;
    logic [KEY_W-1:0]  key_masked;
    logic [7:0]        chr;
    logic [HASH_W-1:0] h_mul;
    logic              div_start, div_done;
    logic [HASH_W-1:0] h_mag;
    logic [SLOT_W-1:0] div_rem;
    logic [SLOT_W-1:0] home;
    logic [SIZE_W-1:0] slot_sum, slot_adv;
    logic [SIZE_W-1:0] st_t0, st_t1, st_t2;
    logic              occupied;
    logic              out_free;
    logic [TC_W:0]     tc_sum;
    logic [TOT_W:0]    tot_sum;
    qphi_tbl_req_t     tbl_req;

    assign len_c = (cmd.key_length > LEN_MAX) ? LEN_MAX : cmd.key_length;

    // bytes past the key length are stored as zero
    always_comb
    begin
        for (int b = 0; b < KEY_W / 8; b++)
        begin
            key_masked[b*8 +: 8] = (LEN_W'(b) < len_c) ? cmd.key_chars[b*8 +: 8] : 8'h00;
        end
    end

    assign chr   = ksh_reg[7:0];
    assign h_mul = h_reg * HASH_W'(HASH_MUL);

    // remainder of |h|; negative hash folded back in the adjust step
    assign h_mag = h_reg[HASH_W-1] ? (~h_reg + HASH_W'(1)) : h_reg;
    assign home  = (h_reg[HASH_W-1] && (div_rem != '0)) ?
                   SLOT_W'(eff_size - {1'b0, div_rem}) : div_rem;

    // incremental quadratic step: slot += (2i+1) mod size, step += 2 mod size
    assign slot_sum = {1'b0, slot_reg} + {1'b0, step_reg};
    assign slot_adv = (slot_sum >= eff_size) ? (slot_sum - eff_size) : slot_sum;
    assign st_t0    = {1'b0, step_reg} + SIZE_W'(2);
    assign st_t1    = (st_t0 >= eff_size) ? (st_t0 - eff_size) : st_t0;
    assign st_t2    = (st_t1 >= eff_size) ? (st_t1 - eff_size) : st_t1;

    assign out_free = !ov_reg || rsp.ready;
    assign tc_sum   = {1'b0, tc_reg} + (TC_W + 1)'(hits_reg);
    assign tot_sum  = {1'b0, tot_reg} + (TOT_W + 1)'(hits_reg);

    assign div_start = (state_reg == ST_HASH) && (left_reg == '0);

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        key_next    = key_reg;
        ksh_next    = ksh_reg;
        left_next   = left_reg;
        h_next      = h_reg;
        slot_next   = slot_reg;
        step_next   = step_reg;
        pi_next     = pi_reg;
        hits_next   = hits_reg;
        found_next  = found_reg;
        stored_next = stored_reg;
        tc_next     = tc_reg;
        tot_next    = tot_reg;
        ov_next     = ov_reg && !rsp.ready;
        o_slot_next = o_slot_reg;
        o_hits_next = o_hits_reg;
        o_half_next = o_half_reg;
        o_full_next = o_full_reg;
        tbl_req     = '{clr: 1'b0, wr_en: 1'b0, slot: slot_reg, key: key_reg};

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    op_next    = cmd.opcode;
                    key_next   = key_masked;
                    ksh_next   = key_masked;
                    left_next  = len_c;
                    h_next     = '0;
                    hits_next  = '0;
                    found_next = 1'b0;
                    state_next = (cmd.opcode == OP_CLEAR) ? ST_FIN : ST_HASH;
                end
            end
            ST_HASH:
            begin
                if (left_reg == '0)
                begin
                    state_next = ST_DIV;
                end
                else
                begin
                    h_next    = h_mul + {{(HASH_W-8){chr[7]}}, chr};
                    ksh_next  = {8'h00, ksh_reg[KEY_W-1:8]};
                    left_next = left_reg - 1'b1;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_ADJ;
                end
            end
            ST_ADJ:
            begin
                slot_next  = home;
                step_next  = (eff_size == SIZE_W'(1)) ? '0 : SLOT_W'(1);
                pi_next    = '0;
                state_next = ST_PROBE;
            end
            ST_PROBE:
            begin
                if (!occupied)
                begin
                    found_next = 1'b1;
                    state_next = ST_FIN;
                end
                else
                begin
                    hits_next = hits_reg + 1'b1;
                    if (pi_reg == SLOT_W'(TABLE_DEPTH - 1))
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        slot_next = SLOT_W'(slot_adv);
                        step_next = SLOT_W'(st_t2);
                        pi_next   = pi_reg + 1'b1;
                    end
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    if (op_reg == OP_CLEAR)
                    begin
                        stored_next = '0;
                        tc_next     = '0;
                        tbl_req.clr = 1'b1;
                        o_slot_next = '0;
                        o_full_next = 1'b0;
                    end
                    else
                    begin
                        tc_next  = tc_sum[TC_W] ? '1 : tc_sum[TC_W-1:0];
                        tot_next = tot_sum[TOT_W] ? '1 : tot_sum[TOT_W-1:0];
                        if (found_reg)
                        begin
                            tbl_req.wr_en = 1'b1;
                            stored_next   = (stored_reg == '1) ? stored_reg
                                                               : stored_reg + 1'b1;
                            o_slot_next   = slot_reg;
                        end
                        else
                        begin
                            o_slot_next = '0;
                        end
                        o_full_next = !found_reg;
                    end
                    o_hits_next = hits_reg;
                    o_half_next = ({stored_next, 1'b0} >= {1'b0, eff_size});
                    ov_next     = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            stored_reg <= '0;
            tc_reg     <= '0;
            tot_reg    <= '0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            stored_reg <= stored_next;
            tc_reg     <= tc_next;
            tot_reg    <= tot_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        key_reg    <= key_next;
        ksh_reg    <= ksh_next;
        left_reg   <= left_next;
        h_reg      <= h_next;
        slot_reg   <= slot_next;
        step_reg   <= step_next;
        pi_reg     <= pi_next;
        hits_reg   <= hits_next;
        found_reg  <= found_next;
        o_slot_reg <= o_slot_next;
        o_hits_reg <= o_hits_next;
        o_half_reg <= o_half_next;
        o_full_reg <= o_full_next;
    end

    // ---------------- sub-blocks ----------------
    qphi_modunit u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (h_mag),
        .divisor   (eff_size),
        .done      (div_done),
        .remainder (div_rem)
    );

    qphi_table u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (tbl_req),
        .rd_slot  (slot_reg),
        .occupied (occupied)
    );

    // ---------------- channels ----------------
    assign cmd.ready             = (state_reg == ST_IDLE);
    assign rsp.valid             = ov_reg;
    assign rsp.slot_index        = o_slot_reg;
    assign rsp.probe_collisions  = o_hits_reg;
    assign rsp.entry_count       = stored_reg;
    assign rsp.table_collisions  = tc_reg;
    assign rsp.total_collisions  = tot_reg;
    assign rsp.load_half_reached = o_half_reg;
    assign rsp.table_full        = o_full_reg;

`ifndef SYNTH
    // one command at a time: after an accept the block stays busy
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready) |=> !cmd.ready)
        else $error("command accepted while previous one in flight");

    // lifetime total never falls below the per-table count
    a_total_ge_table: assert property (@(posedge clk) disable iff (!rst_n)
        tot_reg >= TOT_W'(tc_reg))
        else $error("total collisions below table collisions");

    // a full table reports slot zero
    a_full_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && o_full_reg) |-> (o_slot_reg == '0))
        else $error("full result with non-zero slot");

    // the remainder unit is started only once hashing has finished
    a_div_after_hash: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |=> (state_reg == ST_DIV))
        else $error("remainder started outside hash hand-over");
`endif

endmodule
`default_nettype wire
